### rtl/mlfd_pkg.sv
`timescale 1ns / 1ps
package mlfd_pkg;

	localparam int MARKER_RUN_DEF   = 5;
	localparam int LENGTH_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF   = 24;

	localparam int BYTE_W  = 8;
	localparam int EVENT_W = 3;
	localparam int FLEN_W  = 24;
	localparam int LIMIT_W = 24;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

	localparam logic [BYTE_W-1:0] BYTE_START = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_MID   = 8'h21;
	localparam logic [BYTE_W-1:0] BYTE_END_A = 8'h22;
	localparam logic [BYTE_W-1:0] BYTE_END_B = 8'h23;

	localparam logic [EVENT_W-1:0] EV_DATA      = 3'd0;
	localparam logic [EVENT_W-1:0] EV_DONE      = 3'd1;
	localparam logic [EVENT_W-1:0] EV_PING      = 3'd2;
	localparam logic [EVENT_W-1:0] EV_BAD_START = 3'd3;
	localparam logic [EVENT_W-1:0] EV_BAD_END   = 3'd4;

	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_HUNT  = 3'd0;
	localparam logic [PH_W-1:0] PH_LEN   = 3'd1;
	localparam logic [PH_W-1:0] PH_MID   = 3'd2;
	localparam logic [PH_W-1:0] PH_DATA  = 3'd3;
	localparam logic [PH_W-1:0] PH_END_A = 3'd4;
	localparam logic [PH_W-1:0] PH_END_B = 3'd5;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_LEN = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0]  payload_byte;
		logic [EVENT_W-1:0] event_code;
		logic [FLEN_W-1:0]  frame_length;
	} mlfd_res_t;

endpackage

### rtl/mlfd_core.sv
`timescale 1ns / 1ps
module mlfd_core #(
	parameter int MARKER_RUN   = mlfd_pkg::MARKER_RUN_DEF,
	parameter int LENGTH_BYTES = mlfd_pkg::LENGTH_BYTES_DEF,
	parameter int COUNT_BITS   = mlfd_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [7:0]                    rx_byte,
	input  logic [mlfd_pkg::LIMIT_W-1:0]  max_len,
	output logic                          res_valid,
	output mlfd_pkg::mlfd_res_t           res
);
	import mlfd_pkg::*;

	localparam int LEN_W   = 8 * LENGTH_BYTES;
	localparam int RUN_MAX = (MARKER_RUN > LENGTH_BYTES) ? MARKER_RUN : LENGTH_BYTES;
	localparam int RUN_W   = $clog2(RUN_MAX + 1);
	localparam int CMP_A   = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
	localparam int CMP_W   = (CMP_A > COUNT_BITS) ? CMP_A : COUNT_BITS;
	localparam logic [CMP_W-1:0] CMASK = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);
	localparam logic [RUN_W-1:0] MARK_LAST = RUN_W'(MARKER_RUN - 1);
	localparam logic [RUN_W-1:0] LEN_LAST  = RUN_W'(LENGTH_BYTES - 1);

	logic [PH_W-1:0]       phase_q, phase_d;
	logic [RUN_W-1:0]      run_q, run_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic [CMP_W-1:0]      len_ext, max_ext, limit;
	logic                  len_bad;

	assign len_ext = CMP_W'(len_q);
	assign max_ext = CMP_W'(max_len);
	assign limit   = (max_ext > CMASK) ? CMASK : max_ext;
	assign len_bad = len_q[LEN_W-1] | (len_ext > limit);

	always_comb begin
		phase_d   = phase_q;
		run_d     = run_q;
		len_d     = len_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_LEN: begin
				for (int i = 0; i < LENGTH_BYTES; i++) begin
					if (run_q == RUN_W'(i)) begin
						len_d[8*i +: 8] = rx_byte;
					end
				end
				if (run_q == LEN_LAST) begin
					phase_d = PH_MID;
					run_d   = '0;
				end else begin
					run_d = run_q + RUN_W'(1);
				end
			end
			PH_MID: begin
				if (rx_byte != BYTE_MID) begin
					res_valid = 1'b1;
					res.event_code = EV_BAD_START;
					phase_d = PH_HUNT;
					run_d   = '0;
					len_d   = '0;
					left_d  = '0;
				end else if (run_q == MARK_LAST) begin
					run_d = '0;
					if (len_bad) begin
						res_valid = 1'b1;
						res.event_code = EV_BAD_START;
						phase_d = PH_HUNT;
						len_d   = '0;
						left_d  = '0;
					end else begin
						left_d  = len_ext[COUNT_BITS-1:0];
						phase_d = (len_q == '0) ? PH_END_A : PH_DATA;
					end
				end else begin
					run_d = run_q + RUN_W'(1);
				end
			end
			PH_DATA: begin
				left_d = left_q - COUNT_BITS'(1);
				if (left_d == '0) begin
					phase_d = PH_END_A;
					run_d   = '0;
				end
				res_valid = 1'b1;
				res.payload_byte = rx_byte;
				res.event_code   = EV_DATA;
			end
			PH_END_A, PH_END_B: begin
				if (rx_byte != ((phase_q == PH_END_A) ? BYTE_END_A : BYTE_END_B)) begin
					res_valid = 1'b1;
					res.event_code = EV_BAD_END;
					phase_d = PH_HUNT;
					run_d   = '0;
					len_d   = '0;
					left_d  = '0;
				end else if (run_q == MARK_LAST) begin
					run_d = '0;
					if (phase_q == PH_END_A) begin
						phase_d = PH_END_B;
					end else begin
						phase_d   = PH_HUNT;
						len_d     = '0;
						left_d    = '0;
						res_valid = 1'b1;
						if (len_q == '0) begin
							res.event_code = EV_PING;
						end else begin
							res.event_code   = EV_DONE;
							res.frame_length = len_ext[FLEN_W-1:0];
						end
					end
				end else begin
					run_d = run_q + RUN_W'(1);
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte != BYTE_START) begin
					if (run_q != '0) begin
						res_valid = 1'b1;
						res.event_code = EV_BAD_START;
						run_d  = '0;
						len_d  = '0;
						left_d = '0;
					end
				end else if (run_q == MARK_LAST) begin
					phase_d = PH_LEN;
					run_d   = '0;
					len_d   = '0;
				end else begin
					run_d = run_q + RUN_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			run_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			len_q   <= len_d;
			left_q  <= left_d;
		end
	end

endmodule

### rtl/marker_length_frame_deframer.sv
`timescale 1ns / 1ps
// Deframer for length-prefixed link frames. Received bytes enter on the input
// channel (in_valid, in_stall, rx_byte), one request per byte. Each byte gives
// zero or one result on the output channel (out_valid, out_stall, payload_byte,
// event_code, frame_length): a passed payload byte, a frame complete or ping
// event, or a framing error event after which the block hunts for a new start.
// The largest accepted payload length is written through the APB port at
// address 0 and may only be changed while no frame is in progress.
// A byte accepted at one clock edge is held in an input register, decoded by
// the frame state machine once the output register is free or draining, and
// its result is loaded into the output register. One byte is accepted every
// cycle unless the receiver stalls; the frame state registers update per byte.
// When the receiver stalls, the result holds in the output register and the
// input stalls as soon as the input register is also full, so nothing is lost.
// Reset clears the channel valid flags, puts the block into start hunting and
// sets the length limit to its maximum.
module marker_length_frame_deframer #(
	parameter int MARKER_RUN   = mlfd_pkg::MARKER_RUN_DEF,
	parameter int LENGTH_BYTES = mlfd_pkg::LENGTH_BYTES_DEF,
	parameter int COUNT_BITS   = mlfd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mlfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mlfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mlfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      payload_byte,
	output logic [2:0]                      event_code,
	output logic [23:0]                     frame_length
);
	import mlfd_pkg::*;

	logic [LIMIT_W-1:0] max_len_q;
	logic               s1_valid_q;
	logic [BYTE_W-1:0]  rx_s1;
	logic               out_valid_q;
	mlfd_res_t          out_q;
	logic               advance, fire, res_valid;
	mlfd_res_t          res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? APB_DATA_W'(max_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	mlfd_core #(
		.MARKER_RUN   (MARKER_RUN),
		.LENGTH_BYTES (LENGTH_BYTES),
		.COUNT_BITS   (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (rx_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign event_code   = out_q.event_code;
	assign frame_length = out_q.frame_length;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q && out_stall)
		else $error("input stalled without a pending request");

	a_length_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != EV_DONE |-> frame_length == '0)
		else $error("frame length reported outside a frame complete event");

	a_byte_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != EV_DATA |-> payload_byte == '0)
		else $error("payload byte reported with a non-data event");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_BAD_END)
		else $error("undefined event code");

	a_fire_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !(out_valid_q && $past(res_valid) == 1'b0 && $past(out_valid_q) == 1'b0))
		else $error("output valid without a result");

endmodule
